>>> rtl/core/pfdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfdb_pkg;

   localparam int NUM_AGES    = 8;
   localparam int COEF_W      = 17;
   localparam int SUM_W       = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int PIX_W       = 24;

   // one half in Q16, added before the >> 16 of each term
   localparam logic [24:0] TERM_ROUND = 25'd32768;
   localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PPF     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE    = 3'd5;

   typedef struct packed {
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic       bgr_order;
   } req_type;

   typedef struct packed {
      logic [7:0] out_zero;
      logic [7:0] out_one;
      logic [7:0] out_two;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LATCH = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/per_channel_frame_delay_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake             | payload
// req     | in  | req_valid/req_ready   | req_data (req_type)
// rsp     | out | rsp_valid/rsp_ready   | rsp_data (rsp_type)
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data (64 bit)
//
// One pixel at a time. Each pixel reads the frame store once per held past
// frame through its single read port. The first pixel of a frame first runs
// the coefficient divider over 24 slots: a 26-step restoring divider pass
// per enabled slot, a plain write otherwise.
// Reset is synchronous; the store has no clearing pass.
// The result sits in an output register; a stalled rsp holds the next pixel
// in its final state until the register frees.

module per_channel_frame_delay_blend
   import pfdb_pkg::*;
#(
   parameter int MAX_PAST_FRAMES  = 7,
   parameter int MAX_FRAME_PIXELS = 2097152
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data
);

   localparam int DEPTH = MAX_PAST_FRAMES * MAX_FRAME_PIXELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
   localparam logic [23:0] FRAME_MAX = 24'(MAX_FRAME_PIXELS);
   localparam logic [23:0] PPF_RESET = (307200 > MAX_FRAME_PIXELS) ?
                                       24'(MAX_FRAME_PIXELS) : 24'd307200;
   localparam logic [3:0]  SLOTS     = 4'(MAX_PAST_FRAMES);
   localparam logic [2:0]  DELAY_MAX = 3'(MAX_PAST_FRAMES);

   state_type state_ff, state_in;

   logic [2:0]  delay_ff;
   logic [23:0] ppf_ff;
   logic [63:0] weights_ff;
   logic [7:0]  mask_ff [3];

   logic [2:0]       held_ff, held_in;
   logic [2:0]       newest_ff, newest_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [7:0] pix_ff [3];
   logic       bgr_ff;

   logic [1:0]  lc_c_ff, lc_c_in;
   logic [2:0]  lc_k_ff, lc_k_in;
   logic        div_busy_ff, div_busy_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [11:0] div_rem_ff, div_rem_in;
   logic [25:0] div_num_ff, div_num_in;
   logic [11:0] div_den_ff, div_den_in;

   logic [3:0]       iss_ff, iss_in;
   logic             rd_v_ff, rd_v_in;
   logic [2:0]       rd_age_ff, rd_age_in;
   logic [PIX_W-1:0] rd_data_ff;
   logic [SUM_W-1:0] acc_ff [3];
   logic [SUM_W-1:0] acc_in [3];

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic [PIX_W-1:0] store [DEPTH];
   logic             rd_en, store_we;
   logic [AW-1:0]    rd_addr, wr_addr;

   logic [COEF_W-1:0] coef_ff [3][NUM_AGES];
   logic              coef_we;
   logic [COEF_W-1:0] coef_wdata;

   logic [10:0] total;
   logic        en_cur;
   logic [7:0]  w_cur;
   logic [12:0] trial;
   logic [11:0] rem_step;
   logic [25:0] num_step;
   logic [3:0]  rd_slot, wr_slot;
   logic [7:0]  src [3];
   logic [24:0] prod [3];
   logic [7:0]  sat [3];
   logic        last;
   logic [POS_W-1:0] pos_eff;
   logic [21:0] ppf_raw;
   logic [23:0] ppf_new;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // enabled weight total for the colour being latched
   always_comb begin
      total = '0;
      for (int k = 0; k < NUM_AGES; k++) begin
         if (mask_ff[lc_c_ff][k] && (3'(k) <= held_ff)) begin
            total = total + 11'(weights_ff[8*k +: 8]);
         end
      end
      en_cur = mask_ff[lc_c_ff][lc_k_ff] && (lc_k_ff <= held_ff);
      w_cur  = weights_ff[{lc_k_ff, 3'b000} +: 8];
   end

   always_comb begin
      trial = {div_rem_ff, div_num_ff[25]};
      if (trial >= {1'b0, div_den_ff}) begin
         rem_step = 12'(trial - {1'b0, div_den_ff});
         num_step = {div_num_ff[24:0], 1'b1};
      end else begin
         rem_step = trial[11:0];
         num_step = {div_num_ff[24:0], 1'b0};
      end
   end

   always_comb begin
      rd_slot = {1'b0, newest_ff} + SLOTS + 4'd1 - {1'b0, iss_ff[2:0]};
      if (rd_slot >= SLOTS) begin
         rd_slot = rd_slot - SLOTS;
      end
      wr_slot = {1'b0, newest_ff} + 4'd1;
      if (wr_slot >= SLOTS) begin
         wr_slot = 4'd0;
      end
      rd_addr = AW'(rd_slot) * AW'(MAX_FRAME_PIXELS) + AW'(pos_ff);
      wr_addr = AW'(wr_slot) * AW'(MAX_FRAME_PIXELS) + AW'(pos_ff);
   end

   // one age per cycle: age 0 comes from the held pixel, others from the store
   always_comb begin
      src[0] = (rd_age_ff == 3'd0) ? pix_ff[0] : rd_data_ff[23:16];
      src[1] = (rd_age_ff == 3'd0) ? pix_ff[1] : rd_data_ff[15:8];
      src[2] = (rd_age_ff == 3'd0) ? pix_ff[2] : rd_data_ff[7:0];
      for (int c = 0; c < 3; c++) begin
         prod[c] = 25'(src[c]) * 25'(coef_ff[c][rd_age_ff]) + TERM_ROUND;
         sat[c]  = (acc_ff[c] > 11'd255) ? 8'hFF : acc_ff[c][7:0];
      end
   end

   assign last    = (24'(pos_ff) + 24'd1 >= ppf_ff);
   assign pos_eff = (24'(pos_ff) >= ppf_ff) ? '0 : pos_ff;
   assign ppf_raw = csr_data[21:0];

   always_comb begin
      ppf_new = (ppf_raw == 22'd0) ? 24'd1 : 24'(ppf_raw);
      if (ppf_new > FRAME_MAX) begin
         ppf_new = FRAME_MAX;
      end
   end

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      newest_in    = newest_ff;
      pos_in       = pos_ff;
      lc_c_in      = lc_c_ff;
      lc_k_in      = lc_k_ff;
      div_busy_in  = div_busy_ff;
      div_cnt_in   = div_cnt_ff;
      div_rem_in   = div_rem_ff;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      iss_in       = iss_ff;
      rd_v_in      = 1'b0;
      rd_age_in    = rd_age_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      store_we     = 1'b0;
      coef_we      = 1'b0;
      coef_wdata   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in  = pos_eff;
               lc_c_in = '0;
               lc_k_in = '0;
               div_busy_in = 1'b0;
               iss_in  = '0;
               for (int c = 0; c < 3; c++) begin
                  acc_in[c] = '0;
               end
               state_in = (pos_eff == '0) ? ST_LATCH : ST_RUN;
            end
         end
         ST_LATCH: begin
            if (div_busy_ff) begin
               div_rem_in = rem_step;
               div_num_in = num_step;
               div_cnt_in = div_cnt_ff - 5'd1;
               if (div_cnt_ff == 5'd0) begin
                  div_busy_in = 1'b0;
                  coef_we     = 1'b1;
                  coef_wdata  = num_step[COEF_W-1:0];
               end
            end else if (en_cur && (total != 11'd0)) begin
               div_busy_in = 1'b1;
               div_cnt_in  = 5'd25;
               div_rem_in  = '0;
               div_num_in  = {1'b0, w_cur, 17'd0} + 26'(total);
               div_den_in  = {total, 1'b0};
            end else begin
               coef_we = 1'b1;
            end
            if (coef_we) begin
               if (lc_k_ff == 3'd7) begin
                  lc_k_in = '0;
                  if (lc_c_ff == 2'd2) begin
                     lc_c_in  = '0;
                     state_in = ST_RUN;
                  end else begin
                     lc_c_in = lc_c_ff + 2'd1;
                  end
               end else begin
                  lc_k_in = lc_k_ff + 3'd1;
               end
            end
         end
         ST_RUN: begin
            if (iss_ff <= {1'b0, held_ff}) begin
               rd_v_in   = 1'b1;
               rd_age_in = iss_ff[2:0];
               rd_en     = (iss_ff != 4'd0);
               iss_in    = iss_ff + 4'd1;
            end else if (!rd_v_ff) begin
               state_in = ST_DONE;
            end
            if (rd_v_ff) begin
               for (int c = 0; c < 3; c++) begin
                  acc_in[c] = acc_ff[c] + SUM_W'(prod[c][24:16]);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               store_we         = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_in.out_zero  = bgr_ff ? sat[2] : sat[0];
               rsp_in.out_one   = sat[1];
               rsp_in.out_two   = bgr_ff ? sat[0] : sat[2];
               rsp_in.frame_end = last;
               if (last) begin
                  pos_in    = '0;
                  newest_in = wr_slot[2:0];
                  if (held_ff < delay_ff) begin
                     held_in = held_ff + 3'd1;
                  end
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // history clear on a frame geometry write
      if (csr_valid && ((csr_index == CSR_DELAY) || (csr_index == CSR_PPF))) begin
         held_in   = '0;
         newest_in = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= DELAY_MAX;
         ppf_ff       <= PPF_RESET;
         weights_ff   <= '1;
         mask_ff[0]   <= 8'd1;
         mask_ff[1]   <= 8'd1;
         mask_ff[2]   <= 8'd1;
         held_ff      <= '0;
         newest_ff    <= '0;
         pos_ff       <= '0;
         div_busy_ff  <= 1'b0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lc_c_ff      <= '0;
         lc_k_ff      <= '0;
         iss_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         newest_ff    <= newest_in;
         pos_ff       <= pos_in;
         div_busy_ff  <= div_busy_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
         lc_c_ff      <= lc_c_in;
         lc_k_ff      <= lc_k_in;
         iss_ff       <= iss_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_DELAY:   delay_ff   <= (csr_data[2:0] > DELAY_MAX) ? DELAY_MAX
                                                                       : csr_data[2:0];
               CSR_PPF:     ppf_ff     <= ppf_new;
               CSR_WEIGHTS: weights_ff <= csr_data;
               CSR_RED:     mask_ff[0] <= csr_data[7:0];
               CSR_GREEN:   mask_ff[1] <= csr_data[7:0];
               CSR_BLUE:    mask_ff[2] <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff <= div_cnt_in;
      div_rem_ff <= div_rem_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      rd_age_ff  <= rd_age_in;
      acc_ff     <= acc_in;
      rsp_ff     <= rsp_in;
      if (req_valid && req_ready) begin
         pix_ff[0] <= req_data.bgr_order ? req_data.byte_two : req_data.byte_zero;
         pix_ff[1] <= req_data.byte_one;
         pix_ff[2] <= req_data.bgr_order ? req_data.byte_zero : req_data.byte_two;
         bgr_ff    <= req_data.bgr_order;
      end
      if (coef_we) begin
         coef_ff[lc_c_ff][lc_k_ff] <= coef_wdata;
      end
   end

   // frame store, canonical R,G,B
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
      if (store_we) begin
         store[wr_addr] <= {pix_ff[0], pix_ff[1], pix_ff[2]};
      end
   end

   a_held_le_delay: assert property (@(posedge clock) disable iff (reset)
      held_ff <= delay_ff)
      else $error("frames held exceeds delay");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      24'(pos_ff) < ppf_ff)
      else $error("pixel position beyond frame");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, newest_ff} < SLOTS)
      else $error("newest slot out of range");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      coef_we |-> (coef_wdata <= COEF_ONE))
      else $error("coefficient above one");

   a_wr_after_reads: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (!rd_v_ff && !rd_en))
      else $error("store write overlaps a read");

endmodule

`default_nettype wire

>>> dv/per_channel_frame_delay_blend_test.sv
`timescale 1ns / 1ps

module per_channel_frame_delay_blend_test;
   import pfdb_pkg::*;

   localparam int PAST_MAX   = 7;
   localparam int FRAME_MAX  = 2097152;
   localparam int HOLD_LEN   = 400;
   localparam int IDLE_LIMIT = 20000;

   // indexes past the last register, ignored by the block
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   per_channel_frame_delay_blend dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state, canonical color order R,G,B
   int unsigned delay_cfg, ppf_cfg;
   logic [63:0] weights_cfg;
   logic [7:0] mask_cfg[3];
   int unsigned held, newest, position;
   int unsigned coef[3][8];
   logic [23:0] history[int];

   rsp_type blend_queue[$];
   int errors = 0, pixels_sent = 0, beats_checked = 0, frames_seen = 0;
   bit calm = 0, long_hold = 0;

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [63:0] val);
      case (idx)
         CSR_DELAY: begin
            delay_cfg = (val[2:0] > PAST_MAX) ? PAST_MAX : val[2:0];
            held = 0; newest = 0; position = 0;
         end
         CSR_PPF: begin
            ppf_cfg = val[21:0];
            if (ppf_cfg == 0) ppf_cfg = 1;
            if (ppf_cfg > FRAME_MAX) ppf_cfg = FRAME_MAX;
            held = 0; newest = 0; position = 0;
         end
         CSR_WEIGHTS: weights_cfg = val;
         CSR_RED:     mask_cfg[0] = val[7:0];
         CSR_GREEN:   mask_cfg[1] = val[7:0];
         CSR_BLUE:    mask_cfg[2] = val[7:0];
         default: ;
      endcase
   endfunction

   function automatic void latch_coefs();
      int unsigned total, w;
      for (int c = 0; c < 3; c++) begin
         total = 0;
         for (int k = 0; k < 8; k++)
            if (k <= held && mask_cfg[c][k]) total += weights_cfg[8*k +: 8];
         for (int k = 0; k < 8; k++) begin
            w = weights_cfg[8*k +: 8];
            coef[c][k] = 0;
            if (total != 0 && k <= held && mask_cfg[c][k])
               coef[c][k] = ((w * 131072 + total) / (2 * total)) & 32'h1FFFF;
         end
      end
   endfunction

   function automatic rsp_type blend_pixel(req_type px);
      int unsigned canon[3], sum[3];
      int key;
      logic [23:0] past;
      rsp_type r;
      canon[0] = px.bgr_order ? px.byte_two : px.byte_zero;
      canon[1] = px.byte_one;
      canon[2] = px.bgr_order ? px.byte_zero : px.byte_two;
      if (position >= ppf_cfg) position = 0;
      if (position == 0) latch_coefs();
      for (int c = 0; c < 3; c++) sum[c] = (canon[c] * coef[c][0] + 32768) >> 16;
      for (int k = 1; k <= held && k < 8; k++) begin
         key = ((newest + PAST_MAX + 1 - k) % PAST_MAX) * FRAME_MAX + position;
         past = history.exists(key) ? history[key] : '0;
         for (int c = 0; c < 3; c++)
            sum[c] += (past[23 - 8*c -: 8] * coef[c][k] + 32768) >> 16;
      end
      key = ((newest + 1) % PAST_MAX) * FRAME_MAX + position;
      history[key] = {canon[0][7:0], canon[1][7:0], canon[2][7:0]};
      for (int c = 0; c < 3; c++) if (sum[c] > 255) sum[c] = 255;
      r.frame_end = (position + 1 >= ppf_cfg);
      if (r.frame_end) begin
         position = 0;
         newest = (newest + 1) % PAST_MAX;
         if (held < delay_cfg) held++;
      end else begin
         position++;
      end
      r.out_zero = px.bgr_order ? 8'(sum[2]) : 8'(sum[0]);
      r.out_one  = 8'(sum[1]);
      r.out_two  = px.bgr_order ? 8'(sum[0]) : 8'(sum[2]);
      return r;
   endfunction

   // scoreboard and watchdog
   int quiet = 0;
   always @(posedge clock) begin
      rsp_type want;
      bit moved;
      if (!reset) begin
         moved = 0;
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
            moved = 1;
         end
         if (req_valid && req_ready) begin
            blend_queue.push_back(blend_pixel(req_data));
            moved = 1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1;
            beats_checked++;
            if (blend_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
            end else begin
               want = blend_queue.pop_front();
               if (rsp_data.frame_end) frames_seen++;
               if (rsp_data.out_zero !== want.out_zero) begin
                  errors++;
                  $display("%0t: out_zero expected %0d actual %0d", $time,
                           want.out_zero, rsp_data.out_zero);
               end
               if (rsp_data.out_one !== want.out_one) begin
                  errors++;
                  $display("%0t: out_one expected %0d actual %0d", $time,
                           want.out_one, rsp_data.out_one);
               end
               if (rsp_data.out_two !== want.out_two) begin
                  errors++;
                  $display("%0t: out_two expected %0d actual %0d", $time,
                           want.out_two, rsp_data.out_two);
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  errors++;
                  $display("%0t: frame_end expected %0b actual %0b", $time,
                           want.frame_end, rsp_data.frame_end);
               end
            end
         end
         quiet <= moved ? 0 : quiet + 1;
         if (quiet > IDLE_LIMIT) begin
            $display("per_channel_frame_delay_blend_test: FAIL");
            $finish;
         end
      end
   end

   // receiver
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (HOLD_LEN) @(posedge clock);
            long_hold = 0;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic bgr);
      req_valid <= 1;
      req_data <= '{byte_zero: b0, byte_one: b1, byte_two: b2, bgr_order: bgr};
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_random(int n, logic bgr);
      repeat (n) send_pixel($urandom, $urandom, $urandom, bgr);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (blend_queue.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_all(int d, int p, logic [63:0] w, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b);
      drain();
      write_csr(CSR_DELAY, d);
      write_csr(CSR_PPF, p);
      write_csr(CSR_WEIGHTS, w);
      write_csr(CSR_RED, r);
      write_csr(CSR_GREEN, g);
      write_csr(CSR_BLUE, b);
   endtask

   task automatic test_reset_values();
      send_pixel(8'h00, 8'hFF, 8'h00, 0);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1);
      send_pixel(8'hA5, 8'h5A, 8'h3C, 0);
   endtask

   task automatic test_full_history();
      set_all(7, 1, 64'h01FF_8040_2010_0807, 8'hFF, 8'hAA, 8'h55);
      for (int i = 0; i < 10; i++) send_pixel(i[0] ? 8'hFF : 8'h00, 8'hFF, 8'h80, i[1]);
   endtask

   task automatic test_zero_totals();
      set_all(3, 1, 64'h0, 8'hFF, 8'h00, 8'h0F);
      send_random(4, 0);
      drain();
      write_csr(CSR_WEIGHTS, 64'hFFFF_FFFF_FFFF_FFFF);
      send_random(2, 1);
   endtask

   task automatic test_frame_size_limits();
      set_all(0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 8'h01, 8'h01);
      send_random(3, 0);
      drain();
      write_csr(CSR_PPF, 22'h3FFFFF);
      send_random(3, 1);
      drain();
      write_csr(CSR_PPF, FRAME_MAX);
      send_random(2, 0);
   endtask

   task automatic test_midframe_config();
      set_all(2, 4, 64'h0000_0000_0040_80FF, 8'h07, 8'h03, 8'h05);
      send_random(6, 0);
      drain();
      // takes effect only at the next frame
      write_csr(CSR_WEIGHTS, 64'h0000_0000_00FF_0110);
      write_csr(CSR_GREEN, 8'h06);
      send_random(6, 1);
   endtask

   task automatic test_order_swap();
      set_all(1, 3, 64'h0000_0000_0000_C040, 8'h03, 8'h03, 8'h02);
      for (int i = 0; i < 9; i++) send_pixel($urandom, $urandom, $urandom, $urandom);
      drain();
      write_csr(CSR_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_SPARE_HI, 64'h0);
      send_random(2, 0);
   endtask

   task automatic test_random_traffic(int phases);
      int p, frames;
      for (int ph = 0; ph < phases; ph++) begin
         p = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         set_all($urandom_range(0, 7), p, {$urandom, $urandom}, $urandom, $urandom, $urandom);
         if (ph == 2) long_hold = 1;
         if (ph == phases - 3) calm = 1;
         frames = $urandom_range(2, 10);
         for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 9) == 0)
               send_random(p, 0);
            else
               for (int i = 0; i < p; i++) send_pixel($urandom, $urandom, $urandom, f[0]);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_values();
      test_full_history();
      test_zero_totals();
      test_frame_size_limits();
      test_midframe_config();
      test_order_swap();
      test_random_traffic(22);
      drain();
      repeat (700) @(posedge clock);
      $display("Ran %0d pixels, checked %0d beats over %0d frames.", pixels_sent,
               beats_checked, frames_seen);
      $display("Covered delays 0..7, frame size limits, zero totals, mid-frame updates.");
      if (errors == 0 && blend_queue.size() == 0)
         $display("per_channel_frame_delay_blend_test: PASS");
      else
         $display("per_channel_frame_delay_blend_test: FAIL");
      $finish;
   end

   initial begin
      mask_cfg[0] = 1; mask_cfg[1] = 1; mask_cfg[2] = 1;
      delay_cfg = 7; ppf_cfg = 307200; weights_cfg = '1;
      held = 0; newest = 0; position = 0;
      foreach (coef[c, k]) coef[c][k] = 0;
   end

endmodule

>>> per_channel_frame_delay_blend.f
rtl/core/pfdb_pkg.sv
rtl/core/per_channel_frame_delay_blend.sv
dv/per_channel_frame_delay_blend_test.sv
